// ===== rtl/rlpg_pkg.sv =====
// Shared types, constants and weight functions for the RGB LED pattern generator.
// No dependencies; every other file of the block but rlpg_ram imports this package.
`default_nettype none

package rlpg_pkg;

	localparam int STEP_COUNT  = 32;
	localparam int STEP_BITS   = $clog2(STEP_COUNT);
	localparam int PHASE_BITS  = 8;
	localparam int RAMP_STEP   = 256 / STEP_COUNT;
	localparam int CHANNELS    = 3;

	// Request buffer: two slots, so one request can wait while another plays.
	localparam int REQ_SLOTS   = 2;
	localparam int SLOT_BITS   = $clog2(REQ_SLOTS);

	localparam int IN_TDATA_W  = 80;
	localparam int IN_TUSER_W  = 3;
	localparam int OUT_TDATA_W = 56;

	localparam logic [2:0] MODE_CONST     = 3'd0;
	localparam logic [2:0] MODE_WAVE_FALL = 3'd1;
	localparam logic [2:0] MODE_WAVE_RISE = 3'd2;
	localparam logic [2:0] MODE_RAMP_UP   = 3'd3;
	localparam logic [2:0] MODE_RAMP_DOWN = 3'd4;

	localparam logic [8:0]            FULL_WEIGHT = 9'd256;
	localparam logic [PHASE_BITS-1:0] HALF_TURN   = PHASE_BITS'(128);
	localparam logic [7:0]            DELAY_MAX   = 8'hFF;

	typedef struct packed {
		logic [2:0]            mode;
		logic [7:0]            color_red;
		logic [7:0]            color_green;
		logic [7:0]            color_blue;
		logic [PHASE_BITS-1:0] red_phase;
		logic [PHASE_BITS-1:0] green_phase;
		logic [PHASE_BITS-1:0] blue_phase;
		logic [11:0]           step_delay;
		logic [11:0]           repeat_delay;
		logic [7:0]            smoothing;
	} req_t;

	typedef struct packed {
		logic                 valid;
		logic [STEP_BITS-1:0] step;
		logic                 last;
	} step_ctrl_t;

	typedef struct packed {
		logic [STEP_BITS-1:0] step_index;
		logic [7:0]           red_value;
		logic [7:0]           green_value;
		logic [7:0]           blue_value;
		logic [7:0]           delay_byte;
		logic [7:0]           loop_delay_byte;
		logic [7:0]           smooth_byte;
		logic                 last_step;
	} res_t;

	// round(128 * cos(k * pi / 128)) for k = 0..64.
	function automatic logic [7:0] quarter_cos(input logic [6:0] k);
		logic [7:0] v;
		case (k)
			7'd0, 7'd1, 7'd2, 7'd3: v = 8'd128;
			7'd4, 7'd5, 7'd6:       v = 8'd127;
			7'd7, 7'd8:             v = 8'd126;
			7'd9:  v = 8'd125;  7'd10: v = 8'd124;  7'd11: v = 8'd123;
			7'd12, 7'd13:           v = 8'd122;
			7'd14: v = 8'd121;  7'd15: v = 8'd119;  7'd16: v = 8'd118;
			7'd17: v = 8'd117;  7'd18: v = 8'd116;  7'd19: v = 8'd114;
			7'd20: v = 8'd113;  7'd21: v = 8'd111;  7'd22: v = 8'd110;
			7'd23: v = 8'd108;  7'd24: v = 8'd106;  7'd25: v = 8'd105;
			7'd26: v = 8'd103;  7'd27: v = 8'd101;  7'd28: v = 8'd99;
			7'd29: v = 8'd97;   7'd30: v = 8'd95;   7'd31: v = 8'd93;
			7'd32: v = 8'd91;   7'd33: v = 8'd88;   7'd34: v = 8'd86;
			7'd35: v = 8'd84;   7'd36: v = 8'd81;   7'd37: v = 8'd79;
			7'd38: v = 8'd76;   7'd39: v = 8'd74;   7'd40: v = 8'd71;
			7'd41: v = 8'd68;   7'd42: v = 8'd66;   7'd43: v = 8'd63;
			7'd44: v = 8'd60;   7'd45: v = 8'd58;   7'd46: v = 8'd55;
			7'd47: v = 8'd52;   7'd48: v = 8'd49;   7'd49: v = 8'd46;
			7'd50: v = 8'd43;   7'd51: v = 8'd40;   7'd52: v = 8'd37;
			7'd53: v = 8'd34;   7'd54: v = 8'd31;   7'd55: v = 8'd28;
			7'd56: v = 8'd25;   7'd57: v = 8'd22;   7'd58: v = 8'd19;
			7'd59: v = 8'd16;   7'd60: v = 8'd13;   7'd61: v = 8'd9;
			7'd62: v = 8'd6;    7'd63: v = 8'd3;
			default: v = 8'd0;
		endcase
		return v;
	endfunction

	// round(i * 256 / 31) mod 256: the wave phase of each step.
	function automatic logic [PHASE_BITS-1:0] wave_base(input logic [STEP_BITS-1:0] i);
		logic [7:0] v;
		case (i)
			5'd0:  v = 8'd0;    5'd1:  v = 8'd8;    5'd2:  v = 8'd17;   5'd3:  v = 8'd25;
			5'd4:  v = 8'd33;   5'd5:  v = 8'd41;   5'd6:  v = 8'd50;   5'd7:  v = 8'd58;
			5'd8:  v = 8'd66;   5'd9:  v = 8'd74;   5'd10: v = 8'd83;   5'd11: v = 8'd91;
			5'd12: v = 8'd99;   5'd13: v = 8'd107;  5'd14: v = 8'd116;  5'd15: v = 8'd124;
			5'd16: v = 8'd132;  5'd17: v = 8'd140;  5'd18: v = 8'd149;  5'd19: v = 8'd157;
			5'd20: v = 8'd165;  5'd21: v = 8'd173;  5'd22: v = 8'd182;  5'd23: v = 8'd190;
			5'd24: v = 8'd198;  5'd25: v = 8'd206;  5'd26: v = 8'd215;  5'd27: v = 8'd223;
			5'd28: v = 8'd231;  5'd29: v = 8'd239;  5'd30: v = 8'd248;
			default: v = 8'd0;
		endcase
		return PHASE_BITS'(v);
	endfunction

	// (cos + 1) / 2 scaled to 0..256, unfolded from the quarter wave.
	function automatic logic [8:0] wave_weight(input logic [PHASE_BITS-1:0] p);
		logic [8:0] pw;
		logic [8:0] diff;
		logic [8:0] w;
		pw = 9'(p);
		if (pw <= 9'd64) begin
			w = 9'd128 + 9'(quarter_cos(pw[6:0]));
		end else if (pw <= 9'd128) begin
			diff = 9'd128 - pw;
			w = 9'd128 - 9'(quarter_cos(diff[6:0]));
		end else if (pw <= 9'd192) begin
			diff = pw - 9'd128;
			w = 9'd128 - 9'(quarter_cos(diff[6:0]));
		end else begin
			diff = 9'd256 - pw;
			w = 9'd128 + 9'(quarter_cos(diff[6:0]));
		end
		return w;
	endfunction

	function automatic logic [8:0] channel_weight(input logic [2:0] mode,
			input logic [STEP_BITS-1:0] i, input logic [PHASE_BITS-1:0] shift);
		logic [PHASE_BITS-1:0] p;
		logic [PHASE_BITS-1:0] ramp;
		logic [8:0] w;
		p    = wave_base(i) + shift;
		ramp = PHASE_BITS'(i) * PHASE_BITS'(RAMP_STEP) + shift;
		case (mode)
			MODE_WAVE_FALL: w = wave_weight(p);
			MODE_WAVE_RISE: w = wave_weight(p + HALF_TURN);
			MODE_RAMP_UP:   w = 9'(ramp);
			MODE_RAMP_DOWN: w = FULL_WEIGHT - 9'(ramp);
			default:        w = FULL_WEIGHT;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/rgb_led_pattern_generator_unit.sv =====
// Top level of the RGB LED pattern generator: stream ports, request buffer, pipeline.
// Depends on rlpg_pkg, rlpg_ram, rlpg_sequencer and rlpg_datapath.
//
//   Channel  Direction  Handshake                    Beat contents
//   s_axis   in         s_axis_tvalid/s_axis_tready  one pattern request
//   m_axis   out        m_axis_tvalid/m_axis_tready  one step of a pattern, tlast on step 31
//
// Each accepted request yields 32 output beats, one per cycle while m_axis_tready
// stays high. The single step counter, which reads the request buffer once per step,
// sets the number of beats. The first step passes the buffer read, the weight stage
// and the multiply stage after the request beat. Requests wait in a two-slot buffer
// RAM, so the next request is taken while the current one is still playing. Reset
// clears the slot count, pointers, step counter, step control and valid flags; the
// buffer needs no clearing pass. A stall on m_axis freezes the whole pipeline,
// including the buffer read.
`default_nettype none

module rgb_led_pattern_generator_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,

	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	// color_red, color_green, color_blue, red_phase, green_phase, blue_phase,
	// step_delay, repeat_delay, smoothing (lowest bits first)
	input  wire logic [rlpg_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// mode
	input  wire logic [rlpg_pkg::IN_TUSER_W-1:0]  s_axis_tuser,

	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	// step_index, red_value, green_value, blue_value, delay_byte,
	// loop_delay_byte, smooth_byte, then three zero bits (lowest bits first)
	output logic [rlpg_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// last_step
	output logic                                  m_axis_tlast
);
	import rlpg_pkg::*;

	localparam int RES_DATA_W = STEP_BITS + 6 * 8;

	logic                 in_accept;
	logic                 advance;
	logic                 rd_en;
	logic [SLOT_BITS-1:0] wr_addr;
	logic [SLOT_BITS-1:0] rd_addr;
	step_ctrl_t           ctrl_s1;
	req_t                 req_in;
	req_t                 req_s1;
	res_t                 res;

	assign in_accept = s_axis_tvalid && s_axis_tready;

	// Unpack the request beat into the buffer word.
	always_comb begin
		req_in.mode         = s_axis_tuser[2:0];
		req_in.color_red    = s_axis_tdata[7:0];
		req_in.color_green  = s_axis_tdata[15:8];
		req_in.color_blue   = s_axis_tdata[23:16];
		req_in.red_phase    = s_axis_tdata[31:24];
		req_in.green_phase  = s_axis_tdata[39:32];
		req_in.blue_phase   = s_axis_tdata[47:40];
		req_in.step_delay   = s_axis_tdata[59:48];
		req_in.repeat_delay = s_axis_tdata[71:60];
		req_in.smoothing    = s_axis_tdata[79:72];
	end

	rlpg_sequencer u_sequencer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.advance   (advance),
		.in_ready  (s_axis_tready),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.ctrl_s1   (ctrl_s1)
	);

	// Request buffer: a slot is written only while free, and read only after
	// the cycle in which it was written, so no forwarding path is needed.
	rlpg_ram #(
		.WIDTH ($bits(req_t)),
		.DEPTH (REQ_SLOTS)
	) u_req_ram (
		.clk     (clk),
		.wr_en   (in_accept),
		.wr_addr (wr_addr),
		.wr_data (req_in),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (req_s1)
	);

	rlpg_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl_s1   (ctrl_s1),
		.req_s1    (req_s1),
		.out_ready (m_axis_tready),
		.advance   (advance),
		.out_valid (m_axis_tvalid),
		.res       (res)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - RES_DATA_W)'(0),
		res.smooth_byte, res.loop_delay_byte, res.delay_byte,
		res.blue_value, res.green_value, res.red_value, res.step_index};
	assign m_axis_tlast = res.last_step;

endmodule

`default_nettype wire

// ===== rtl/rlpg_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none

module rlpg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rlpg_sequencer.sv =====
// Request slot bookkeeping and step counter; issues one buffer read per step.
// Depends on rlpg_pkg.
`default_nettype none

module rlpg_sequencer (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_accept,
	input  wire logic                          advance,
	output logic                               in_ready,
	output logic [rlpg_pkg::SLOT_BITS-1:0]     wr_addr,
	output logic                               rd_en,
	output logic [rlpg_pkg::SLOT_BITS-1:0]     rd_addr,
	output rlpg_pkg::step_ctrl_t               ctrl_s1
);
	import rlpg_pkg::*;

	localparam logic [SLOT_BITS:0]     SLOTS_FULL = (SLOT_BITS+1)'(REQ_SLOTS);
	localparam logic [SLOT_BITS-1:0]   LAST_SLOT  = SLOT_BITS'(REQ_SLOTS - 1);
	localparam logic [STEP_BITS-1:0]   LAST_STEP  = STEP_BITS'(STEP_COUNT - 1);

	logic [SLOT_BITS:0]   count_q;
	logic [SLOT_BITS-1:0] wr_ptr_q;
	logic [SLOT_BITS-1:0] rd_ptr_q;
	logic [STEP_BITS-1:0] step_q;
	logic                 issue;
	logic                 at_last;
	logic                 release_slot;

	assign in_ready     = (count_q != SLOTS_FULL);
	assign issue        = advance && (count_q != '0);
	assign at_last      = (step_q == LAST_STEP);
	assign release_slot = issue && at_last;
	assign wr_addr      = wr_ptr_q;
	assign rd_addr      = rd_ptr_q;
	assign rd_en        = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			wr_ptr_q      <= '0;
			rd_ptr_q      <= '0;
			step_q        <= '0;
			ctrl_s1.valid <= 1'b0;
			ctrl_s1.step  <= '0;
			ctrl_s1.last  <= 1'b0;
		end else begin
			count_q <= count_q + (SLOT_BITS+1)'(in_accept) - (SLOT_BITS+1)'(release_slot);
			if (in_accept) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + SLOT_BITS'(1);
			end
			if (release_slot) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + SLOT_BITS'(1);
			end
			if (issue) begin
				step_q <= at_last ? '0 : step_q + STEP_BITS'(1);
			end
			if (advance) begin
				ctrl_s1.valid <= issue;
				ctrl_s1.step  <= step_q;
				ctrl_s1.last  <= at_last;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/rlpg_datapath.sv =====
// Weight stage, multiply stage and output register of the step pipeline.
// Depends on rlpg_pkg.
`default_nettype none

module rlpg_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire rlpg_pkg::step_ctrl_t ctrl_s1,
	input  wire rlpg_pkg::req_t       req_s1,
	input  wire logic                 out_ready,
	output logic                      advance,
	output logic                      out_valid,
	output rlpg_pkg::res_t            res
);
	import rlpg_pkg::*;

	logic                 valid_s2;
	logic [STEP_BITS-1:0] step_s2;
	logic                 last_s2;
	logic [8:0]           weight_s2 [CHANNELS];
	logic [7:0]           color_s2  [CHANNELS];
	logic [7:0]           delay_s2;
	logic [7:0]           loop_s2;
	logic [7:0]           smooth_s2;
	logic                 out_valid_q;
	res_t                 res_q;

	logic [7:0]            color_c [CHANNELS];
	logic [PHASE_BITS-1:0] phase_c [CHANNELS];
	logic [16:0]           prod    [CHANNELS];

	assign advance   = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign res       = res_q;

	always_comb begin
		color_c[0] = req_s1.color_red;
		color_c[1] = req_s1.color_green;
		color_c[2] = req_s1.color_blue;
		phase_c[0] = req_s1.red_phase;
		phase_c[1] = req_s1.green_phase;
		phase_c[2] = req_s1.blue_phase;
		for (int c = 0; c < CHANNELS; c++) begin
			prod[c] = 17'(weight_s2[c]) * 17'(color_s2[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s2    <= ctrl_s1.valid;
			out_valid_q <= valid_s2;
		end
	end

	// Payload registers move with the pipeline and need no reset.
	always_ff @(posedge clk) begin
		if (advance) begin
			step_s2   <= ctrl_s1.step;
			last_s2   <= ctrl_s1.last;
			for (int c = 0; c < CHANNELS; c++) begin
				weight_s2[c] <= channel_weight(req_s1.mode, ctrl_s1.step, phase_c[c]);
				color_s2[c]  <= color_c[c];
			end
			delay_s2  <= (|req_s1.step_delay[11:8]) ? DELAY_MAX : req_s1.step_delay[7:0];
			loop_s2   <= (|req_s1.repeat_delay[11:8]) ? DELAY_MAX : req_s1.repeat_delay[7:0];
			smooth_s2 <= req_s1.smoothing;

			res_q.step_index      <= step_s2;
			res_q.red_value       <= prod[0][15:8];
			res_q.green_value     <= prod[1][15:8];
			res_q.blue_value      <= prod[2][15:8];
			res_q.delay_byte      <= delay_s2;
			res_q.loop_delay_byte <= loop_s2;
			res_q.smooth_byte     <= smooth_s2;
			res_q.last_step       <= last_s2;
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_rgb_led_pattern_generator_unit.sv =====
// Self-checking testbench for rgb_led_pattern_generator_unit: every accepted request is turned
// into its 32 expected steps by an independent predictor and matched beat by beat on m_axis.
// Depends on rlpg_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_rgb_led_pattern_generator_unit;

	import rlpg_pkg::*;

	// The three spare mode codes, all of which behave like the constant mode.
	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	localparam int LONG_HOLD   = 400;   // cycles the receiver blocks m_axis during the hold
	localparam int TAIL_CYCLES = 40;    // quiet time after the last step, well past the latency

	// One pattern request, channels indexed red, green, blue.
	typedef struct packed {
		logic [2:0]      mode;
		logic [2:0][7:0] color;
		logic [2:0][7:0] phase;
		logic [11:0]     step_delay;
		logic [11:0]     repeat_delay;
		logic [7:0]      smoothing;
	} led_request_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_MOSTLY,
		READY_PERIODIC
	} pace_style_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;

	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;

	rgb_led_pattern_generator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Rounded 128 * cos(k * pi / 128) over a quarter turn; the other three quarters
	// follow by symmetry.
	logic [7:0] cos_quarter [0:64] = '{
		128, 128, 128, 128, 127, 127, 127, 126, 126, 125, 124, 123, 122, 122, 121, 119,
		118, 117, 116, 114, 113, 111, 110, 108, 106, 105, 103, 101,  99,  97,  95,  93,
		 91,  88,  86,  84,  81,  79,  76,  74,  71,  68,  66,  63,  60,  58,  55,  52,
		 49,  46,  43,  40,  37,  34,  31,  28,  25,  22,  19,  16,  13,   9,   6,   3,
		  0
	};

	led_request_t   pending_requests[$];   // requests waiting for the driver
	res_t           expected_steps[$];     // steps owed by the block, oldest first

	int error_count     = 0;
	int steps_checked   = 0;
	int requests_taken  = 0;
	int mode_taken [0:7] = '{default: 0};

	// Handshake between the sequence and the receiver for the long output stall.
	int holds_requested = 0;
	int holds_served    = 0;
	int hold_left       = 0;

	// Sender and receiver pacing state.
	int burst_left = 0;
	int gap_left   = 0;
	pace_style_t pace_style = READY_ALWAYS;
	int pace_left    = 0;
	int pace_period  = 4;
	int pace_duty    = 2;
	int cycle_count  = 0;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Raised-cosine weight 0..256 for a phase in 1/256 turn.
	function automatic int unsigned cosine_weight(input logic [7:0] p);
		int unsigned pi;
		int unsigned w;
		pi = p;
		if (pi <= 64)
			w = 128 + cos_quarter[pi];
		else if (pi <= 128)
			w = 128 - cos_quarter[128 - pi];
		else if (pi <= 192)
			w = 128 - cos_quarter[pi - 128];
		else
			w = 128 + cos_quarter[256 - pi];
		return w;
	endfunction

	// Weight of one channel at one step; anything that is not a wave or a ramp is
	// a constant full-scale weight.
	function automatic int unsigned step_weight(input logic [2:0] mode, input int unsigned i,
			input logic [7:0] shift);
		logic [7:0]  p;
		int unsigned w;
		case (mode)
			MODE_WAVE_FALL, MODE_WAVE_RISE: begin
				// round(i * 256 / 31), which wraps to zero on the last step
				p = 8'((i * 512 + (STEP_COUNT - 1)) / (2 * (STEP_COUNT - 1))) + shift;
				if (mode == MODE_WAVE_RISE)
					p = p + 8'd128;
				w = cosine_weight(p);
			end
			MODE_RAMP_UP: begin
				p = 8'(i * (256 / STEP_COUNT)) + shift;
				w = p;
			end
			MODE_RAMP_DOWN: begin
				p = 8'(i * (256 / STEP_COUNT)) + shift;
				w = 256 - p;
			end
			default: w = 256;
		endcase
		return w;
	endfunction

	function automatic logic [7:0] clamp_delay(input logic [11:0] v);
		return (v >= 12'h100) ? 8'hFF : v[7:0];
	endfunction

	function automatic logic [IN_TDATA_W-1:0] pack_request(input led_request_t r);
		return {r.smoothing, r.repeat_delay, r.step_delay, r.phase, r.color};
	endfunction

	// Works out all steps of a request exactly as it crossed the input bus.
	task automatic predict_pattern(input logic [IN_TUSER_W-1:0] mode,
			input logic [IN_TDATA_W-1:0] data);
		led_request_t r;
		res_t         s;
		logic [7:0]   chan [0:2];
		{r.smoothing, r.repeat_delay, r.step_delay, r.phase, r.color} = data;
		r.mode = mode;
		for (int i = 0; i < STEP_COUNT; i++) begin
			for (int c = 0; c < 3; c++)
				chan[c] = 8'((step_weight(r.mode, i, r.phase[c]) * r.color[c]) >> 8);
			s.step_index      = STEP_BITS'(i);
			s.red_value       = chan[0];
			s.green_value     = chan[1];
			s.blue_value      = chan[2];
			s.delay_byte      = clamp_delay(r.step_delay);
			s.loop_delay_byte = clamp_delay(r.repeat_delay);
			s.smooth_byte     = r.smoothing;
			s.last_step       = (i == STEP_COUNT - 1);
			expected_steps.push_back(s);
		end
	endtask

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_request(input logic [2:0] mode,
			input logic [7:0] red, input logic [7:0] green, input logic [7:0] blue,
			input logic [7:0] red_ph, input logic [7:0] green_ph, input logic [7:0] blue_ph,
			input logic [11:0] step_dly, input logic [11:0] loop_dly, input logic [7:0] smooth);
		led_request_t r;
		r.mode         = mode;
		r.color        = {blue, green, red};
		r.phase        = {blue_ph, green_ph, red_ph};
		r.step_delay   = step_dly;
		r.repeat_delay = loop_dly;
		r.smoothing    = smooth;
		pending_requests.push_back(r);
	endtask

	// Delays land on either side of the saturation point often enough to matter.
	function automatic logic [11:0] random_delay();
		logic [11:0] v;
		case ($urandom_range(0, 3))
			0: v = 12'($urandom_range(0, 255));
			1: v = 12'($urandom_range(250, 262));
			default: v = 12'($urandom);
		endcase
		return v;
	endfunction

	function automatic logic [7:0] random_color();
		logic [7:0] v;
		case ($urandom_range(0, 7))
			0: v = 8'h00;
			1: v = 8'hFF;
			default: v = 8'($urandom);
		endcase
		return v;
	endfunction

	function automatic led_request_t random_request();
		led_request_t r;
		r.mode = 3'($urandom_range(0, 7));
		for (int c = 0; c < 3; c++) begin
			r.color[c] = random_color();
			r.phase[c] = 8'($urandom);
		end
		r.step_delay   = random_delay();
		r.repeat_delay = random_delay();
		r.smoothing    = 8'($urandom);
		return r;
	endfunction

	// Gaps between bursts: often none, sometimes short, sometimes longer than a
	// whole pattern so that new requests arrive at every point of a playback.
	function automatic int next_gap();
		int g;
		case ($urandom_range(0, 3))
			0: g = 0;
			1: g = $urandom_range(1, 4);
			2: g = $urandom_range(5, 40);
			default: g = $urandom_range(41, 80);
		endcase
		return g;
	endfunction

	// Waits until the driver has nothing left to send and every step has come back.
	task automatic wait_drained();
		while (pending_requests.size() != 0 || s_axis_tvalid || expected_steps.size() != 0)
			@(posedge clk);
	endtask

	task check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			error_count++;
		end
	endtask

	// ------------------------------------------------------------------
	// Request driver: bursts of beats separated by random gaps. A beat that is
	// on the bus stays there until the block takes it.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : drive_requests
		led_request_t r;
		logic         next_valid;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_pattern(s_axis_tuser, s_axis_tdata);
				requests_taken++;
				mode_taken[s_axis_tuser]++;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				next_valid = 1'b0;
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_requests.size() != 0) begin
					r = pending_requests.pop_front();
					s_axis_tdata <= pack_request(r);
					s_axis_tuser <= r.mode;
					next_valid = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 6);
						gap_left   = next_gap();
					end
				end
				s_axis_tvalid <= next_valid;
			end
		end
	end

	// ------------------------------------------------------------------
	// Step receiver: tready follows one of several styles that change now and
	// then. A long hold requested by the sequence overrides everything, which
	// fills the request buffer and backs up s_axis.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : pace_output
		logic next_ready;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_left == 0 && holds_served != holds_requested) begin
				holds_served++;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_ready = 1'b0;
			end else begin
				if (pace_left == 0) begin
					pace_style  = pace_style_t'($urandom_range(0, 3));
					pace_left   = $urandom_range(40, 300);
					pace_period = $urandom_range(2, 9);
					pace_duty   = $urandom_range(1, pace_period - 1);
				end else begin
					pace_left--;
				end
				case (pace_style)
					READY_ALWAYS:   next_ready = 1'b1;
					READY_RANDOM:   next_ready = 1'($urandom_range(0, 1));
					READY_MOSTLY:   next_ready = ($urandom_range(0, 7) != 0);
					default:        next_ready = ((cycle_count % pace_period) < pace_duty);
				endcase
			end
			cycle_count++;
			m_axis_tready <= next_ready;
		end
	end

	// ------------------------------------------------------------------
	// Step checker: each beat taken on m_axis is matched against the oldest
	// expected step, field by field, including the zero padding of tdata.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : check_steps
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_steps.size() == 0) begin
				$display("%0t ns: step beat with nothing expected, actual tdata %0h tlast %0b",
					$time, m_axis_tdata, m_axis_tlast);
				error_count++;
			end else begin
				want = expected_steps.pop_front();
				check_field("step_index",      want.step_index,      m_axis_tdata[4:0]);
				check_field("red_value",       want.red_value,       m_axis_tdata[12:5]);
				check_field("green_value",     want.green_value,     m_axis_tdata[20:13]);
				check_field("blue_value",      want.blue_value,      m_axis_tdata[28:21]);
				check_field("delay_byte",      want.delay_byte,      m_axis_tdata[36:29]);
				check_field("loop_delay_byte", want.loop_delay_byte, m_axis_tdata[44:37]);
				check_field("smooth_byte",     want.smooth_byte,     m_axis_tdata[52:45]);
				check_field("tdata padding",   0,                    m_axis_tdata[55:53]);
				check_field("last_step",       want.last_step,       m_axis_tlast);
				steps_checked++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequence: directed requests, a full drain, a random phase that starts
	// under a long output stall, another drain, then a second random phase.
	// ------------------------------------------------------------------
	initial begin : run_sequence
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Constant mode at both color extremes, and delays around saturation.
		queue_request(MODE_CONST, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00,
			12'd0, 12'd0, 8'h00);
		queue_request(MODE_CONST, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
			12'd255, 12'd256, 8'hFF);
		queue_request(MODE_CONST, 8'h80, 8'h01, 8'hFE, 8'h40, 8'h80, 8'hC0,
			12'hFFF, 12'd15, 8'h5A);
		// Falling and rising waves at quarter-turn phase offsets.
		queue_request(MODE_WAVE_FALL, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h40, 8'h80,
			12'd16, 12'd255, 8'hA5);
		queue_request(MODE_WAVE_FALL, 8'hFF, 8'h7F, 8'h01, 8'hFF, 8'hC0, 8'h01,
			12'hFFF, 12'hFFF, 8'h01);
		queue_request(MODE_WAVE_RISE, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h40, 8'h80,
			12'd257, 12'd1, 8'h80);
		queue_request(MODE_WAVE_RISE, 8'h80, 8'h01, 8'hC8, 8'hFF, 8'h20, 8'h60,
			12'hAAA, 12'h555, 8'h7F);
		queue_request(MODE_WAVE_FALL, 8'h00, 8'h00, 8'h00, 8'h7F, 8'h81, 8'h3F,
			12'd0, 12'hFFF, 8'hFE);
		// Ramps with shifts that wrap and that land on the full weight.
		queue_request(MODE_RAMP_UP, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h08, 8'hFF,
			12'd100, 12'd200, 8'h33);
		queue_request(MODE_RAMP_UP, 8'hFF, 8'h64, 8'h00, 8'h80, 8'hF8, 8'h07,
			12'h800, 12'h100, 8'hCC);
		queue_request(MODE_RAMP_DOWN, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h08, 8'hFF,
			12'd254, 12'd255, 8'h0F);
		queue_request(MODE_RAMP_DOWN, 8'h64, 8'hFF, 8'h01, 8'hC8, 8'h01, 8'hFA,
			12'h555, 12'hAAA, 8'hF0);
		// Spare mode codes all play a constant pattern.
		queue_request(MODE_SPARE_5, 8'hFF, 8'h00, 8'h80, 8'h12, 8'h34, 8'h56,
			12'd300, 12'd0, 8'h11);
		queue_request(MODE_SPARE_6, 8'h00, 8'hFF, 8'h7F, 8'hAB, 8'hCD, 8'hEF,
			12'd0, 12'd300, 8'h22);
		queue_request(MODE_SPARE_7, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h80,
			12'hFFF, 12'hFFF, 8'hFF);
		queue_request(MODE_WAVE_RISE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
			12'd255, 12'd256, 8'h00);

		// The sender sits idle here until every step so far has been checked.
		wait_drained();

		// Stall the output while a long queue of requests keeps s_axis busy.
		holds_requested++;
		repeat (175) pending_requests.push_back(random_request());
		wait_drained();

		repeat (180) pending_requests.push_back(random_request());
		wait_drained();

		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d requests (modes 0..7: %0d %0d %0d %0d %0d %0d %0d %0d) and",
			requests_taken, mode_taken[0], mode_taken[1], mode_taken[2], mode_taken[3],
			mode_taken[4], mode_taken[5], mode_taken[6], mode_taken[7]);
		$display("checked %0d step beats under bursty input, varied output stalls and one long hold.",
			steps_checked);
		if (error_count == 0) begin
			$display("rgb_led_pattern_generator_unit test passed");
		end else begin
			$display("rgb_led_pattern_generator_unit test failed");
		end
		$finish;
	end

	// Watchdog, far above the slowest legal run of this sequence.
	initial begin : watchdog
		#4_000_000;
		$display("Timeout with %0d steps still expected", expected_steps.size());
		$display("rgb_led_pattern_generator_unit test failed");
		$finish;
	end

endmodule
